// ===== hw/rtl/isml_pkg.sv =====
// Shared types, constants and codes for the Ising Metropolis lattice block.
// No dependencies; every other file refers to it by scoped names.
package isml_pkg;

	// Lattice side is 2**SIDE_LOG; row and column split by shift and mask.
	localparam int SIDE_LOG = 6;
	localparam int SIDE     = 1 << SIDE_LOG;
	localparam int SITES    = SIDE * SIDE;

	localparam int SITE_W   = 12;
	localparam int FRAC_W   = 16;
	localparam int DE_W     = 5;
	localparam int ENERGY_W = 15;
	localparam int MAGNET_W = 14;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic [SIDE_LOG-1:0]        row_t;
	typedef logic [SIDE-1:0]            line_t;
	typedef logic [SITE_W-1:0]          site_t;
	typedef logic [FRAC_W-1:0]          frac_t;
	typedef logic signed [DE_W-1:0]     de_t;
	typedef logic signed [ENERGY_W-1:0] energy_t;
	typedef logic signed [MAGNET_W-1:0] magnet_t;

	localparam energy_t ENERGY_RESET = energy_t'(-2 * SITES);
	localparam magnet_t MAGNET_RESET = magnet_t'(SITES);

	typedef enum logic {
		KIND_ATTEMPT = 1'b0,
		KIND_FORCE   = 1'b1
	} kind_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESH_FOUR  = 1'b0,
		CFG_THRESH_EIGHT = 1'b1
	} cfg_reg_e;

	// Row reads: three rows of the lattice per item
	typedef struct packed {
		logic en;
		row_t up;
		row_t cur;
		row_t down;
	} rd_req_t;

	typedef struct packed {
		line_t up;
		line_t cur;
		line_t down;
	} rd_rows_t;

	typedef struct packed {
		logic  en;
		row_t  row;
		line_t line;
	} wr_req_t;

	// Item held in the decision stage
	typedef struct packed {
		logic  kind;
		frac_t frac;
		logic  want;
		logic  site_ok;
		row_t  col;
	} item_t;

	typedef struct packed {
		logic  flip;
		logic  new_spin;
		logic  old_spin;
		de_t   de;
		line_t new_line;
	} decision_t;

endpackage

// ===== hw/rtl/isml_site_if.sv =====
// Input channel of the Ising lattice block: one flip attempt or forced spin per word.
// Depends on isml_pkg for field widths.
interface isml_site_if;
	logic                valid;
	logic                ready;
	logic                kind;
	isml_pkg::site_t     site_index;
	isml_pkg::frac_t     random_fraction;
	logic                spin_value;

	modport source (output valid, kind, site_index, random_fraction, spin_value,
		input ready);
	modport sink (input valid, kind, site_index, random_fraction, spin_value,
		output ready);
endinterface

// ===== hw/rtl/isml_result_if.sv =====
// Result channel of the Ising lattice block: one word per accepted input word.
// Depends on isml_pkg for field widths.
interface isml_result_if;
	logic                valid;
	logic                ready;
	logic                flipped;
	logic                new_spin;
	isml_pkg::de_t       energy_change;
	isml_pkg::energy_t   total_energy;
	isml_pkg::magnet_t   total_magnet;

	modport source (output valid, flipped, new_spin, energy_change, total_energy,
		total_magnet, input ready);
	modport sink (input valid, flipped, new_spin, energy_change, total_energy,
		total_magnet, output ready);
endinterface

// ===== hw/rtl/isml_lattice.sv =====
// Spin lattice storage: three row-wide copies read at up/current/down rows,
// one shared write, reset clearing pass, and bypass of the last written row.
// Depends on isml_pkg.
module isml_lattice (
	input  logic               clk,
	input  logic               arst_n,
	input  isml_pkg::rd_req_t  rd,
	input  isml_pkg::wr_req_t  wr,
	output isml_pkg::rd_rows_t rows,
	output logic               clearing
);

	isml_pkg::line_t mem_up   [0:isml_pkg::SIDE-1];
	isml_pkg::line_t mem_cur  [0:isml_pkg::SIDE-1];
	isml_pkg::line_t mem_down [0:isml_pkg::SIDE-1];

	logic            clear_q;
	isml_pkg::row_t  clr_row_q;

	isml_pkg::line_t up_q, cur_q, down_q;
	isml_pkg::row_t  up_row_q, cur_row_q, down_row_q;

	logic            wr_seen_q;
	isml_pkg::row_t  wr_row_q;
	isml_pkg::line_t wr_line_q;

	logic            mem_we;
	isml_pkg::row_t  mem_row;
	isml_pkg::line_t mem_line;

	always_comb begin
		if (clear_q) begin
			mem_we   = 1'b1;
			mem_row  = clr_row_q;
			mem_line = '1;
		end else begin
			mem_we   = wr.en;
			mem_row  = wr.row;
			mem_line = wr.line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_row_q <= '0;
		end else if (clear_q) begin
			clr_row_q <= isml_pkg::row_t'(clr_row_q + 1'b1);
			if (clr_row_q == isml_pkg::row_t'(isml_pkg::SIDE - 1))
				clear_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_up[mem_row]   <= mem_line;
			mem_cur[mem_row]  <= mem_line;
			mem_down[mem_row] <= mem_line;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			up_q       <= mem_up[rd.up];
			cur_q      <= mem_cur[rd.cur];
			down_q     <= mem_down[rd.down];
			up_row_q   <= rd.up;
			cur_row_q  <= rd.cur;
			down_row_q <= rd.down;
		end
	end

	// Last item write; a read taken on the same edge sees the old row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_seen_q <= 1'b0;
		else if (wr.en && !clear_q)
			wr_seen_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr.en && !clear_q) begin
			wr_row_q  <= wr.row;
			wr_line_q <= wr.line;
		end
	end

	always_comb begin
		rows.up   = (wr_seen_q && up_row_q == wr_row_q)   ? wr_line_q : up_q;
		rows.cur  = (wr_seen_q && cur_row_q == wr_row_q)  ? wr_line_q : cur_q;
		rows.down = (wr_seen_q && down_row_q == wr_row_q) ? wr_line_q : down_q;
	end

	assign clearing = clear_q;

endmodule

// ===== hw/rtl/isml_flip_unit.sv =====
// Flip decision: neighbor sum, energy change, Metropolis or force test, new row.
// Pure combinational; depends on isml_pkg.
module isml_flip_unit (
	input  isml_pkg::item_t     item,
	input  isml_pkg::rd_rows_t  rows,
	input  isml_pkg::frac_t     thresh_four,
	input  isml_pkg::frac_t     thresh_eight,
	output isml_pkg::decision_t dec
);

	isml_pkg::row_t col_l, col_r;
	logic           s;
	logic [2:0]     k;
	logic [2:0]     m;
	logic           flip;
	isml_pkg::de_t  de;

	always_comb begin
		col_l = isml_pkg::row_t'(item.col - 1'b1);
		col_r = isml_pkg::row_t'(item.col + 1'b1);
		s = rows.cur[item.col];
		k = {2'b00, rows.up[item.col]} + {2'b00, rows.down[item.col]}
			+ {2'b00, rows.cur[col_l]} + {2'b00, rows.cur[col_r]};
		// neighbors aligned with the site
		m = s ? k : 3'd4 - k;

		case (m)
			3'd0:    de = -isml_pkg::de_t'(8);
			3'd1:    de = -isml_pkg::de_t'(4);
			3'd2:    de = isml_pkg::de_t'(0);
			3'd3:    de = isml_pkg::de_t'(4);
			3'd4:    de = isml_pkg::de_t'(8);
			default: de = isml_pkg::de_t'(0);
		endcase

		if (item.kind == isml_pkg::KIND_FORCE)
			flip = (s != item.want);
		else if (m <= 3'd2)
			flip = 1'b1;
		else if (m == 3'd3)
			flip = (item.frac < thresh_four);
		else
			flip = (item.frac < thresh_eight);

		dec.old_spin = s;
		if (item.site_ok) begin
			dec.flip     = flip;
			dec.new_spin = s ^ flip;
			dec.de       = de;
		end else begin
			dec.flip     = 1'b0;
			dec.new_spin = 1'b0;
			dec.de       = '0;
		end
		dec.new_line = rows.cur;
		dec.new_line[item.col] = ~s;
	end

endmodule

// ===== hw/rtl/ising_metropolis_lattice.sv =====
// Metropolis Ising lattice: 64 x 64 periodic spin lattice with running energy
// and magnetization. Each input word is accepted at one edge; the three lattice
// rows around the site are read from row-wide memory into registers at that edge,
// and the decision stage then makes the decision, writes the row back and loads
// the result register once that register is empty or being drained, and a new
// word is taken every cycle while results are drained. Back-to-back items on the
// same or neighboring rows are handled by a bypass of the last written row. After
// reset a clearing pass (one row per cycle) sets every spin up; no input word is
// taken during it, configuration writes are. Thresholds are unsigned Q0.16 and
// the test is strict (fraction < threshold). An index beyond the lattice changes
// nothing and reports zeros with the current totals.
module ising_metropolis_lattice (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [isml_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [isml_pkg::CFG_DATA_W-1:0]     cfg_data,
	isml_site_if.sink                           attempt,
	isml_result_if.source                       result
);

	isml_pkg::frac_t     thresh_four_q, thresh_eight_q;
	isml_pkg::energy_t   energy_total_q;
	isml_pkg::magnet_t   magnet_total_q;

	logic                s1_valid_q;
	isml_pkg::item_t     item_s1;
	isml_pkg::row_t      row_s1;

	logic                out_valid_q;
	logic                flipped_q, new_spin_q;
	isml_pkg::de_t       de_q;

	isml_pkg::rd_req_t   rd;
	isml_pkg::wr_req_t   wr;
	isml_pkg::rd_rows_t  rows;
	isml_pkg::decision_t dec;
	logic                clearing;
	logic                in_fire, s1_adv;
	isml_pkg::row_t      in_row, in_col;

	assign in_row = isml_pkg::row_t'(32'(attempt.site_index) >> isml_pkg::SIDE_LOG);
	assign in_col = isml_pkg::row_t'(attempt.site_index);

	assign s1_adv        = s1_valid_q && (!out_valid_q || result.ready);
	assign attempt.ready = !clearing && (!s1_valid_q || s1_adv);
	assign in_fire       = attempt.valid && attempt.ready;

	always_comb begin
		rd.en   = in_fire;
		rd.cur  = in_row;
		rd.up   = isml_pkg::row_t'(in_row - 1'b1);
		rd.down = isml_pkg::row_t'(in_row + 1'b1);
		wr.en   = s1_adv && dec.flip;
		wr.row  = row_s1;
		wr.line = dec.new_line;
	end

	isml_lattice u_lattice (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.wr       (wr),
		.rows     (rows),
		.clearing (clearing)
	);

	isml_flip_unit u_flip (
		.item         (item_s1),
		.rows         (rows),
		.thresh_four  (thresh_four_q),
		.thresh_eight (thresh_eight_q),
		.dec          (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_four_q  <= '0;
			thresh_eight_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				isml_pkg::CFG_THRESH_FOUR:  thresh_four_q  <= cfg_data;
				isml_pkg::CFG_THRESH_EIGHT: thresh_eight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_fire)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.kind    <= attempt.kind;
			item_s1.frac    <= attempt.random_fraction;
			item_s1.want    <= attempt.spin_value;
			item_s1.site_ok <= (32'(attempt.site_index) < 32'(isml_pkg::SITES));
			item_s1.col     <= in_col;
			row_s1          <= in_row;
		end
	end

	// Totals only move when a result is loaded, so they double as its payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_total_q <= isml_pkg::ENERGY_RESET;
			magnet_total_q <= isml_pkg::MAGNET_RESET;
		end else if (s1_adv && dec.flip) begin
			energy_total_q <= energy_total_q + isml_pkg::energy_t'(dec.de);
			if (dec.old_spin)
				magnet_total_q <= magnet_total_q - isml_pkg::magnet_t'(2);
			else
				magnet_total_q <= magnet_total_q + isml_pkg::magnet_t'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			flipped_q  <= dec.flip;
			new_spin_q <= dec.new_spin;
			de_q       <= dec.de;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.flipped       = flipped_q;
	assign result.new_spin      = new_spin_q;
	assign result.energy_change = de_q;
	assign result.total_energy  = energy_total_q;
	assign result.total_magnet  = magnet_total_q;

endmodule
